// ===== src/s5rp_pkg.sv =====
// shared types, codes and constants of the socks5 client reply parser
// no dependencies; imported by every module of the block

package s5rp_pkg;

   // command codes of an input beat
   localparam logic [1:0] CMD_START    = 2'd0;
   localparam logic [1:0] CMD_BYTE     = 2'd1;
   localparam logic [1:0] CMD_LINK_ERR = 2'd2;

   // protocol constants
   localparam logic [7:0] SOCKS_VER       = 8'd5;
   localparam logic [7:0] METHOD_NONE     = 8'h00;
   localparam logic [7:0] METHOD_USERPASS = 8'h02;
   localparam logic [7:0] METHOD_REJECT   = 8'hff;
   localparam logic [7:0] AUTH_OK         = 8'h00;
   localparam logic [7:0] REP_MAX         = 8'd8;
   localparam logic [3:0] REP_SATURATED   = 4'd9;
   localparam logic [7:0] ATYP_IPV4       = 8'd1;
   localparam logic [7:0] ATYP_DOMAIN     = 8'd3;
   localparam logic [7:0] ATYP_IPV6       = 8'd4;
   localparam logic [8:0] ADDR_LEN_IPV4   = 9'd6;
   localparam logic [8:0] ADDR_LEN_IPV6   = 9'd18;
   localparam logic [8:0] PORT_LEN        = 9'd2;

   // configuration port
   localparam int unsigned CSR_ADDR_W    = 3;
   localparam int unsigned CSR_DATA_W    = 32;
   localparam logic        CSR_IDX_CREDS = 1'b0;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_SEND_CREDS = 3'd1,
      EV_SEND_CONN  = 3'd2,
      EV_DONE       = 3'd3,
      EV_ERROR      = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_PROTO  = 3'd1,
      ERR_METHOD = 3'd2,
      ERR_AUTH   = 3'd3,
      ERR_LINK   = 3'd4
   } error_type;

   typedef enum logic [2:0] {
      RC_SUCCEEDED   = 3'd0,
      RC_UNKNOWN     = 3'd1,
      RC_UNREACHABLE = 3'd2,
      RC_REFUSED     = 3'd3,
      RC_BAD_ATYP    = 3'd4
   } reply_type;

   typedef struct packed {
      event_type event_res;
      error_type error_kind;
      reply_type reply_code;
   } result_type;

   // rep is already saturated to 4 bits
   function automatic reply_type map_reply(input logic [3:0] rep);
      reply_type rc;
      unique case (rep)
         4'd0:    rc = RC_SUCCEEDED;
         4'd4:    rc = RC_UNREACHABLE;
         4'd5:    rc = RC_REFUSED;
         4'd8:    rc = RC_BAD_ATYP;
         default: rc = RC_UNKNOWN;
      endcase
      return rc;
   endfunction

endpackage

// ===== src/s5rp_req_if.sv =====
// input channel of the socks5 client reply parser: valid/ready plus command and byte
// no dependencies

interface s5rp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// ===== src/s5rp_rsp_if.sv =====
// result channel of the socks5 client reply parser: valid/ready plus event, error and reply code
// no dependencies

interface s5rp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [2:0] error_kind;
   logic [2:0] reply_code;

   modport source (output valid, output event_res, output error_kind, output reply_code,
                   input ready);
   modport sink   (input valid, input event_res, input error_kind, input reply_code,
                   output ready);
endinterface

// ===== src/s5rp_csr.sv =====
// apb-style configuration register file (creds_present)
// depends on s5rp_pkg

module s5rp_csr
   import s5rp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic                  creds_present
);

   logic creds_ff;
   logic wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == CSR_IDX_CREDS);

   always_ff @(posedge clock) begin
      if (reset) begin
         creds_ff <= 1'b0;
      end else if (wr_en) begin
         creds_ff <= pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_CREDS) begin
         prdata[0] = creds_ff;
      end
   end

   assign creds_present = creds_ff;

endmodule

// ===== src/s5rp_core.sv =====
// session state and per-beat reply checks of the socks5 client reply parser
// depends on s5rp_pkg

module s5rp_core
   import s5rp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [1:0] cmd,
   input  logic [7:0] rx_byte,
   input  logic       creds_present,
   output result_type result
);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_METHOD = 3'd1,
      PH_CREDS  = 3'd2,
      PH_HEADER = 3'd3,
      PH_DOMLEN = 3'd4,
      PH_ADDR   = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [1:0] pos_ff, pos_in;
   logic       first_ok_ff, first_ok_in;
   logic [3:0] saved_reply_ff, saved_reply_in;
   logic [8:0] left_ff, left_in;
   logic [8:0] left_dec;
   logic       bad_method;

   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      first_ok_in    = first_ok_ff;
      saved_reply_in = saved_reply_ff;
      left_in        = left_ff;
      result         = '{EV_NONE, ERR_NONE, RC_SUCCEEDED};
      left_dec       = (left_ff != 9'd0) ? left_ff - 9'd1 : left_ff;
      bad_method     = creds_present ? (rx_byte != METHOD_USERPASS)
                                     : (rx_byte != METHOD_NONE);

      unique case (cmd)
         CMD_START: begin
            phase_in    = PH_METHOD;
            pos_in      = 2'd0;
            first_ok_in = 1'b0;
         end
         CMD_LINK_ERR: begin
            if (phase_ff != PH_IDLE) begin
               result.event_res  = EV_ERROR;
               result.error_kind = ERR_LINK;
               phase_in          = PH_IDLE;
               pos_in            = 2'd0;
            end
         end
         CMD_BYTE: begin
            unique case (phase_ff)
               PH_METHOD, PH_CREDS: begin
                  if (pos_ff == 2'd0) begin
                     first_ok_in = (rx_byte == SOCKS_VER);
                     pos_in      = 2'd1;
                  end else begin
                     result.event_res = EV_ERROR;
                     if (phase_ff == PH_METHOD) begin
                        priority if (!first_ok_ff) begin
                           result.error_kind = ERR_PROTO;
                        end else if (rx_byte == METHOD_REJECT) begin
                           result.error_kind = ERR_METHOD;
                        end else if (bad_method) begin
                           result.error_kind = ERR_PROTO;
                        end else begin
                           result.event_res = creds_present ? EV_SEND_CREDS : EV_SEND_CONN;
                        end
                     end else begin
                        priority if (!first_ok_ff) begin
                           result.error_kind = ERR_PROTO;
                        end else if (rx_byte != AUTH_OK) begin
                           result.error_kind = ERR_AUTH;
                        end else begin
                           result.event_res = EV_SEND_CONN;
                        end
                     end
                     pos_in = 2'd0;
                     priority case (result.event_res)
                        EV_SEND_CREDS: begin
                           phase_in    = PH_CREDS;
                           first_ok_in = 1'b0;
                        end
                        EV_SEND_CONN: begin
                           phase_in    = PH_HEADER;
                           first_ok_in = 1'b0;
                        end
                        default: phase_in = PH_IDLE;
                     endcase
                  end
               end
               PH_HEADER: begin
                  unique case (pos_ff)
                     2'd0: begin
                        first_ok_in = (rx_byte == SOCKS_VER);
                        pos_in      = 2'd1;
                     end
                     2'd1: begin
                        saved_reply_in = (rx_byte > REP_MAX) ? REP_SATURATED : rx_byte[3:0];
                        pos_in         = 2'd2;
                     end
                     2'd2: pos_in = 2'd3;
                     default: begin
                        // atyp byte closes the header
                        pos_in = 2'd0;
                        priority if (!first_ok_ff || ({4'd0, saved_reply_ff} > REP_MAX) ||
                                     (rx_byte != ATYP_IPV4 && rx_byte != ATYP_DOMAIN &&
                                      rx_byte != ATYP_IPV6)) begin
                           result.event_res  = EV_ERROR;
                           result.error_kind = ERR_PROTO;
                           phase_in          = PH_IDLE;
                        end else if (rx_byte == ATYP_DOMAIN) begin
                           phase_in = PH_DOMLEN;
                        end else begin
                           left_in  = (rx_byte == ATYP_IPV4) ? ADDR_LEN_IPV4 : ADDR_LEN_IPV6;
                           phase_in = PH_ADDR;
                        end
                     end
                  endcase
               end
               PH_DOMLEN: begin
                  // domain name plus the two port bytes
                  left_in  = {1'b0, rx_byte} + PORT_LEN;
                  phase_in = PH_ADDR;
               end
               PH_ADDR: begin
                  left_in = left_dec;
                  if (left_dec == 9'd0) begin
                     result.event_res  = EV_DONE;
                     result.reply_code = map_reply(saved_reply_ff);
                     phase_in          = PH_IDLE;
                     pos_in            = 2'd0;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         pos_ff         <= 2'd0;
         first_ok_ff    <= 1'b0;
         saved_reply_ff <= 4'd0;
         left_ff        <= 9'd0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         first_ok_ff    <= first_ok_in;
         saved_reply_ff <= saved_reply_in;
         left_ff        <= left_in;
      end
   end

   a_start_enters_method: assert property (@(posedge clock) disable iff (reset)
      fire && cmd == CMD_START |=> phase_ff == PH_METHOD && pos_ff == 2'd0)
      else $error("start beat did not open the method phase");

   a_link_err_goes_idle: assert property (@(posedge clock) disable iff (reset)
      fire && cmd == CMD_LINK_ERR |=> phase_ff == PH_IDLE)
      else $error("link error left the session busy");

   a_idle_byte_no_event: assert property (@(posedge clock) disable iff (reset)
      fire && cmd == CMD_BYTE && phase_ff == PH_IDLE |-> result.event_res == EV_NONE)
      else $error("byte while idle raised an event");

endmodule

// ===== src/socks5_client_reply_parser.sv =====
// top level of the socks5 client reply parser: input register, check logic, result register
// a result beat is registered in the result register as its input beat leaves the input register
// one beat per cycle until a result waits; then the input register holds one beat and stalls
// the session state updates as each beat moves from the input register into the result register
// reset (synchronous, active high) empties both registers, sets the session idle, creds_present 0
// depends on s5rp_pkg, s5rp_req_if, s5rp_rsp_if, s5rp_csr, s5rp_core

module socks5_client_reply_parser
   import s5rp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   s5rp_req_if.sink              req_ch,
   s5rp_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic       in_valid_ff;
   logic [1:0] in_cmd_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_res_ff;
   result_type step_res;
   logic       advance;
   logic       creds_present;

   // a beat leaves the input register when the result register is free or draining
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   s5rp_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .creds_present (creds_present)
   );

   s5rp_core u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance),
      .cmd           (in_cmd_ff),
      .rx_byte       (in_byte_ff),
      .creds_present (creds_present),
      .result        (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_cmd_ff  <= req_ch.cmd;
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.event_res  = out_res_ff.event_res;
   assign rsp_ch.error_kind = out_res_ff.error_kind;
   assign rsp_ch.reply_code = out_res_ff.reply_code;

   a_err_kind_only_on_error: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.event_res != EV_ERROR |-> out_res_ff.error_kind == ERR_NONE)
      else $error("error kind set on a non-error result beat");

   a_reply_only_on_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.event_res != EV_DONE |-> out_res_ff.reply_code == RC_SUCCEEDED)
      else $error("reply code set on a result beat that is not done");

   a_input_held_until_done: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_cmd_ff) && $stable(in_byte_ff))
      else $error("pending input beat lost before processing");

endmodule
